// ===== sv/ipv4_lpm_pkg.sv =====
// shared types, constants and helpers for the ipv4 longest prefix match unit
// no dependencies

package ipv4_lpm_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam int IFACE_COUNT         = 16;

   localparam int ADDR_W   = 32;
   localparam int IFACE_W  = 4;
   localparam int STATUS_W = 2;
   localparam int REQ_W    = 136;
   localparam int RSP_W    = 72;

   localparam logic KIND_ADD    = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]  dest;
      logic [ADDR_W-1:0]  mask;
      logic [ADDR_W-1:0]  gateway;
      logic [IFACE_W-1:0] iface;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } match_ctrl_type;

   function automatic logic [IFACE_W-1:0] sat_iface(input logic [IFACE_W-1:0] ifc);
      logic [8:0] lim;
      lim = 9'(IFACE_COUNT);
      if ({5'd0, ifc} >= lim) begin
         return IFACE_W'(IFACE_COUNT - 1);
      end
      return ifc;
   endfunction

endpackage

// ===== sv/ipv4_lpm_table.sv =====
// route table storage: one write port, one registered read port
// depends on ipv4_lpm_pkg

module ipv4_lpm_table
   import ipv4_lpm_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IdxW-1:0] wr_addr,
   input  entry_type       wr_data,
   input  logic [IdxW-1:0] rd_addr,
   output entry_type       rd_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ipv4_lpm_match.sv =====
// prefix compare unit that keeps the best route seen so far
// depends on ipv4_lpm_pkg

module ipv4_lpm_match
   import ipv4_lpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  match_ctrl_type     ctrl,
   input  logic [ADDR_W-1:0]  addr,
   input  entry_type          entry,
   output logic               found,
   output logic [ADDR_W-1:0]  best_gateway,
   output logic [IFACE_W-1:0] best_iface,
   output logic [ADDR_W-1:0]  best_mask
);

   logic               found_ff, found_in;
   logic [ADDR_W-1:0]  gateway_ff, gateway_in;
   logic [IFACE_W-1:0] iface_ff, iface_in;
   logic [ADDR_W-1:0]  mask_ff, mask_in;
   logic               hit, better;

   assign hit    = ((addr ^ entry.dest) & entry.mask) == '0;
   assign better = !found_ff || (entry.mask > mask_ff);

   always_comb begin
      found_in   = found_ff;
      gateway_in = gateway_ff;
      iface_in   = iface_ff;
      mask_in    = mask_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (ctrl.valid && hit && better) begin
         found_in   = 1'b1;
         gateway_in = entry.gateway;
         iface_in   = entry.iface;
         mask_in    = entry.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      gateway_ff <= gateway_in;
      iface_ff   <= iface_in;
      mask_ff    <= mask_in;
   end

   assign found        = found_ff;
   assign best_gateway = gateway_ff;
   assign best_iface   = iface_ff;
   assign best_mask    = mask_ff;

endmodule

// ===== sv/ipv4_longest_prefix_match_unit.sv =====
// top level of the ipv4 longest prefix match unit: sequencer, result register
// depends on ipv4_lpm_pkg, ipv4_lpm_table, ipv4_lpm_match
//
// channel  dir  tuser            tdata
// req      in   kind             dest, mask, gateway, iface, lookup addr
// rsp      out  status           hop gateway, hop iface, hop mask
//
// add: table written at the transfer unless full, result loaded into rsp from the done state
// lookup: one table read and compare per entry, straight to the done state on an empty table
// not ready from a transfer until its result is loaded into the rsp register
// result waits in the sequencer while rsp is stalled; no clearing pass after reset

module ipv4_longest_prefix_match_unit
   import ipv4_lpm_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [0:0]       req_tuser,  // kind
   input  logic [REQ_W-1:0] req_tdata,  // route_dest, route_mask, route_gateway,
                                        // route_iface, lookup_addr, zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [1:0]       rsp_tuser,  // status
   output logic [RSP_W-1:0] rsp_tdata   // hop_gateway, hop_iface, hop_mask, zero pad
);

   localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                rd_last_ff, rd_last_in;
   logic                kind_ff, kind_in;
   logic [STATUS_W-1:0] add_status_ff, add_status_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;

   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]          rsp_tuser_ff, rsp_tuser_in;
   logic [RSP_W-1:0]    rsp_tdata_ff, rsp_tdata_in;

   logic                accept, full, issue, last_issue, slot_free;
   logic                wr_en;
   entry_type           wr_data, rd_data;
   match_ctrl_type      mctrl;
   logic                found;
   logic [ADDR_W-1:0]   best_gateway, best_mask;
   logic [IFACE_W-1:0]  best_iface;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CntW'(TABLE_DEPTH));
   assign issue      = (state_ff == ST_SCAN);
   assign last_issue = (CntW'(idx_ff) + CntW'(1)) == count_ff;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   assign wr_en           = accept && (req_tuser[0] == KIND_ADD) && !full;
   assign wr_data.dest    = req_tdata[31:0];
   assign wr_data.mask    = req_tdata[63:32];
   assign wr_data.gateway = req_tdata[95:64];
   assign wr_data.iface   = sat_iface(req_tdata[99:96]);

   assign mctrl.clear = accept;
   assign mctrl.valid = rd_vld_ff;

   ipv4_lpm_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IdxW-1:0]),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   ipv4_lpm_match u_match (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (mctrl),
      .addr         (addr_ff),
      .entry        (rd_data),
      .found        (found),
      .best_gateway (best_gateway),
      .best_iface   (best_iface),
      .best_mask    (best_mask)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rd_vld_in     = issue;
      rd_last_in    = issue && last_issue;
      kind_in       = kind_ff;
      add_status_in = add_status_ff;
      addr_in       = addr_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_tuser[0];
               addr_in = req_tdata[131:100];
               idx_in  = '0;
               if (req_tuser[0] == KIND_ADD) begin
                  state_in = ST_DONE;
                  if (full) begin
                     add_status_in = STATUS_FULL;
                  end else begin
                     add_status_in = STATUS_OK;
                     count_in      = count_ff + CntW'(1);
                  end
               end else if (count_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (last_issue) begin
               state_in = ST_WAIT;
            end else begin
               idx_in = idx_ff + IdxW'(1);
            end
         end
         ST_WAIT: begin
            if (rd_last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in      = ST_IDLE;
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               if (kind_ff == KIND_LOOKUP && found) begin
                  rsp_tuser_in        = STATUS_OK;
                  rsp_tdata_in[31:0]  = best_gateway;
                  rsp_tdata_in[35:32] = best_iface;
                  rsp_tdata_in[67:36] = best_mask;
               end else if (kind_ff == KIND_LOOKUP) begin
                  rsp_tuser_in = STATUS_NO_MATCH;
               end else begin
                  rsp_tuser_in = add_status_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_vld_ff     <= rd_vld_in;
         rd_last_ff    <= rd_last_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      add_status_ff <= add_status_in;
      addr_ff       <= addr_in;
      rsp_tuser_ff  <= rsp_tuser_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TABLE_DEPTH))
      else $error("route count above table depth");

   a_full_no_store: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser[0] == KIND_ADD && full) |=> $stable(count_ff))
      else $error("route stored into full table");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_WAIT))
      else $error("table read outside of scan");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && slot_free) |=> (rsp_tvalid_ff && state_ff == ST_IDLE))
      else $error("result not loaded into rsp register");
`endif

endmodule
